[sv/ohs_pkg.sv]
// Shared constants, types and helpers of the smoothed orientation histogram.
package ohs_pkg;

   localparam int MAX_CELLS        = 262144;
   localparam int MAX_AXIS_BINS    = 512;
   localparam int WEIGHT_FRAC_BITS = 16;

   localparam int CELL_AW   = $clog2(MAX_CELLS);
   localparam int BIN_W     = $clog2(MAX_AXIS_BINS);
   localparam int AXIS_W    = BIN_W + 1;
   localparam int CFG_N_W   = 10;
   localparam int STRIDE_W  = 2 * AXIS_W;
   localparam int PROD_W    = BIN_W + STRIDE_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int ANGLE_W   = 16;
   localparam int BIG_W     = 15;
   localparam int CELL_W    = 40;
   localparam int DIV_CNT_W = $clog2(ANGLE_W);
   localparam int IDX_IN_W  = 18;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 16;

   localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};

   localparam longint W_ONE    = longint'(1) << WEIGHT_FRAC_BITS;
   localparam longint W_FACE   = ((longint'(448) << WEIGHT_FRAC_BITS) + 3000) / 6000;
   localparam longint W_EDGE   = ((longint'(16) << WEIGHT_FRAC_BITS) + 600) / 1200;
   localparam longint W_CORNER = ((longint'(6) << WEIGHT_FRAC_BITS) + 400) / 800;
   localparam longint W_CENTRE = W_ONE - 6 * W_FACE - 12 * W_EDGE - 8 * W_CORNER;

   localparam int W_W = WEIGHT_FRAC_BITS + 1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIN_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_N_PHI1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_N_BIG = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_N_PHI2 = 3'd4;

   // Neighbor offset codes.
   localparam logic [1:0] OFS_DOWN = 2'd0;
   localparam logic [1:0] OFS_HOLD = 2'd1;
   localparam logic [1:0] OFS_UP   = 2'd2;

   typedef struct packed {
      logic       load;
      logic       div_step;
      logic       bin_load;
      logic       addr_a;
      logic       addr_b;
      logic       rd;
      logic       wr;
      logic       clr_step;
      logic       out_load;
      logic [1:0] d1;
      logic [1:0] db;
      logic [1:0] d2;
   } cmd_type;

   typedef struct packed {
      logic is_read;
      logic smooth;
      logic clr_last;
      logic out_busy;
   } sts_type;

   // Effective axis count: zero acts as one bin, oversize clamps.
   function automatic logic [AXIS_W-1:0] axis_count(input logic [CFG_N_W-1:0] n);
      logic [AXIS_W-1:0] r;
      if (n == '0) begin
         r = AXIS_W'(1);
      end else if (n > CFG_N_W'(MAX_AXIS_BINS)) begin
         r = AXIS_W'(MAX_AXIS_BINS);
      end else begin
         r = AXIS_W'(n);
      end
      return r;
   endfunction

   // Step one bin along a wrapping axis.
   function automatic logic [BIN_W-1:0] wrap_step(input logic [BIN_W-1:0] i,
                                                  input logic [1:0] d,
                                                  input logic [AXIS_W-1:0] n);
      logic [BIN_W-1:0] r;
      logic [AXIS_W-1:0] nm1;
      logic [AXIS_W-1:0] ip1;
      nm1 = n - AXIS_W'(1);
      ip1 = AXIS_W'(i) + AXIS_W'(1);
      case (d)
         OFS_DOWN: r = (i == '0) ? nm1[BIN_W-1:0] : i - BIN_W'(1);
         OFS_UP:   r = (ip1 >= n) ? '0 : ip1[BIN_W-1:0];
         default:  r = i;
      endcase
      return r;
   endfunction

endpackage

[sv/ohs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module ohs_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 262144
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[sv/ohs_ctrl.sv]
// Sequencer: clearing sweep, division steps and the per-cell update loop.
module ohs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ohs_pkg::sts_type sts,
   output ohs_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_BIN, S_CA, S_CB, S_RD, S_WT, S_WR, S_DONE
   } state_type;

   state_type                      state_ff;
   logic [ohs_pkg::DIV_CNT_W-1:0]  div_cnt_ff;
   logic [1:0]                     d1_ff, db_ff, d2_ff;
   logic                           last_cell;

   assign last_cell = sts.is_read || !sts.smooth ||
      (d1_ff == ohs_pkg::OFS_UP && db_ff == ohs_pkg::OFS_UP && d2_ff == ohs_pkg::OFS_UP);

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.d1       = d1_ff;
      cmd.db       = db_ff;
      cmd.d2       = d2_ff;
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.clr_step = (state_ff == S_CLEAR);
      cmd.div_step = (state_ff == S_DIV);
      cmd.bin_load = (state_ff == S_BIN);
      cmd.addr_a   = (state_ff == S_CA);
      cmd.addr_b   = (state_ff == S_CB);
      cmd.rd       = (state_ff == S_RD);
      cmd.wr       = (state_ff == S_WR);
      cmd.out_load = (state_ff == S_DONE) && !sts.out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         div_cnt_ff <= '0;
         d1_ff      <= ohs_pkg::OFS_HOLD;
         db_ff      <= ohs_pkg::OFS_HOLD;
         d2_ff      <= ohs_pkg::OFS_HOLD;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               if (sts.clr_last) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               div_cnt_ff <= '0;
               if (req_valid) state_ff <= S_DIV;
            end
            S_DIV: begin
               // Reads skip binning and go to the address states; the divide step here is unused.
               if (sts.is_read) begin
                  d1_ff    <= ohs_pkg::OFS_HOLD;
                  db_ff    <= ohs_pkg::OFS_HOLD;
                  d2_ff    <= ohs_pkg::OFS_HOLD;
                  state_ff <= S_CA;
               end else begin
                  div_cnt_ff <= div_cnt_ff + ohs_pkg::DIV_CNT_W'(1);
                  if (div_cnt_ff == ohs_pkg::DIV_CNT_W'(ohs_pkg::ANGLE_W - 1)) begin
                     state_ff <= S_BIN;
                  end
               end
            end
            S_BIN: begin
               if (sts.smooth) begin
                  d1_ff <= ohs_pkg::OFS_DOWN;
                  db_ff <= ohs_pkg::OFS_DOWN;
                  d2_ff <= ohs_pkg::OFS_DOWN;
               end else begin
                  d1_ff <= ohs_pkg::OFS_HOLD;
                  db_ff <= ohs_pkg::OFS_HOLD;
                  d2_ff <= ohs_pkg::OFS_HOLD;
               end
               state_ff <= S_CA;
            end
            S_CA: state_ff <= S_CB;
            S_CB: state_ff <= S_RD;
            S_RD: state_ff <= S_WT;
            S_WT: state_ff <= S_WR;
            S_WR: begin
               if (last_cell) begin
                  state_ff <= S_DONE;
               end else begin
                  // Advance the 3x3x3 offset counter, last axis fastest.
                  state_ff <= S_CA;
                  if (d2_ff != ohs_pkg::OFS_UP) begin
                     d2_ff <= d2_ff + 2'd1;
                  end else begin
                     d2_ff <= ohs_pkg::OFS_DOWN;
                     if (db_ff != ohs_pkg::OFS_UP) begin
                        db_ff <= db_ff + 2'd1;
                     end else begin
                        db_ff <= ohs_pkg::OFS_DOWN;
                        d1_ff <= d1_ff + 2'd1;
                     end
                  end
               end
            end
            S_DONE: begin
               if (!sts.out_busy) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[sv/ohs_dp.sv]
// Datapath: settings, angle dividers, cell address math, RAM update, result register.
module ohs_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  ohs_pkg::cmd_type                cmd,
   output ohs_pkg::sts_type                sts,
   input  logic                            csr_we,
   input  logic [ohs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ohs_pkg::CSR_W-1:0]       csr_wdata,
   input  logic                            req_type,
   input  logic [ohs_pkg::ANGLE_W-1:0]     phi1_angle,
   input  logic [ohs_pkg::BIG_W-1:0]       big_phi_angle,
   input  logic [ohs_pkg::ANGLE_W-1:0]     phi2_angle,
   input  logic [ohs_pkg::IDX_IN_W-1:0]    read_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ohs_pkg::IDX_IN_W-1:0]    cell_index,
   output logic [ohs_pkg::CELL_W-1:0]      cell_value
);

   localparam int AW = ohs_pkg::AXIS_W;
   localparam int BW = ohs_pkg::BIN_W;
   localparam int DW = ohs_pkg::ANGLE_W;
   localparam int CA = ohs_pkg::CELL_AW;

   // Settings.
   logic                smooth_ff;
   logic [DW-1:0]       bin_size_ff;
   logic [9:0]          n1_cfg_ff, nb_cfg_ff, n2_cfg_ff;

   // Item.
   logic                is_read_ff;
   logic [ohs_pkg::IDX_IN_W-1:0] rindex_ff;
   logic [AW-1:0]       n1_ff, nb_ff, n2_ff;
   logic [ohs_pkg::STRIDE_W-1:0] s2_ff;
   logic [DW-1:0]       quo_ff [3];
   logic [DW-1:0]       rem_ff [3];
   logic [BW-1:0]       bin_ff [3];

   // Address pipeline.
   logic [ohs_pkg::PROD_W-1:0]   p1_ff;
   logic [ohs_pkg::STRIDE_W-1:0] pb_ff;
   logic [BW-1:0]                j2_ff;
   logic [ohs_pkg::W_W-1:0]      w_ff;
   logic                         centre_ff;
   logic [CA-1:0]                addr_ff;
   logic                         in_range_ff;
   logic [ohs_pkg::IDX_IN_W-1:0] centre_idx_ff;
   logic [ohs_pkg::CELL_W-1:0]   val_ff;

   // Clearing sweep and RAM.
   logic [CA-1:0]                clr_addr_ff;
   logic                         ram_we;
   logic [CA-1:0]                ram_waddr;
   logic [ohs_pkg::CELL_W-1:0]   ram_wdata;
   logic [ohs_pkg::CELL_W-1:0]   ram_rdata;

   // Result register.
   logic                         rsp_valid_ff;
   logic [ohs_pkg::IDX_IN_W-1:0] rsp_index_ff;
   logic [ohs_pkg::CELL_W-1:0]   rsp_value_ff;

   logic [DW-1:0]       dividend [3];
   logic [AW-1:0]       n_eff [3];
   logic [BW-1:0]       j1, jb;
   logic [1:0]          moved;
   logic [ohs_pkg::W_W-1:0] w_in;
   logic [ohs_pkg::SUM_W-1:0] addr_full_in;
   logic [ohs_pkg::CELL_W:0]  sum_in;
   logic [ohs_pkg::CELL_W-1:0] sat_in;

   assign dividend[0] = phi1_angle;
   assign dividend[1] = DW'(big_phi_angle);
   assign dividend[2] = phi2_angle;
   assign n_eff[0] = n1_ff;
   assign n_eff[1] = nb_ff;
   assign n_eff[2] = n2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_ff   <= 1'b0;
         bin_size_ff <= DW'(640);
         n1_cfg_ff   <= 10'd72;
         nb_cfg_ff   <= 10'd36;
         n2_cfg_ff   <= 10'd72;
      end else if (csr_we) begin
         case (csr_index)
            ohs_pkg::CSR_SMOOTH:   smooth_ff   <= csr_wdata[0];
            ohs_pkg::CSR_BIN_SIZE: bin_size_ff <= csr_wdata;
            ohs_pkg::CSR_N_PHI1:   n1_cfg_ff   <= csr_wdata[9:0];
            ohs_pkg::CSR_N_BIG:    nb_cfg_ff   <= csr_wdata[9:0];
            ohs_pkg::CSR_N_PHI2:   n2_cfg_ff   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // Latch the item, then run one restoring divide step per lane per cycle.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         is_read_ff <= req_type;
         rindex_ff  <= read_index;
         n1_ff      <= ohs_pkg::axis_count(n1_cfg_ff);
         nb_ff      <= ohs_pkg::axis_count(nb_cfg_ff);
         n2_ff      <= ohs_pkg::axis_count(n2_cfg_ff);
         for (int k = 0; k < 3; k++) begin
            quo_ff[k] <= dividend[k];
            rem_ff[k] <= '0;
         end
      end else if (cmd.div_step) begin
         for (int k = 0; k < 3; k++) begin
            if ({rem_ff[k], quo_ff[k][DW-1]} >= {1'b0, bin_size_ff}) begin
               rem_ff[k] <= DW'({rem_ff[k], quo_ff[k][DW-1]} - {1'b0, bin_size_ff});
               quo_ff[k] <= {quo_ff[k][DW-2:0], 1'b1};
            end else begin
               rem_ff[k] <= {rem_ff[k][DW-2:0], quo_ff[k][DW-1]};
               quo_ff[k] <= {quo_ff[k][DW-2:0], 1'b0};
            end
         end
      end
      // A zero bin size leaves an all-ones quotient, which clamps below.
      if (cmd.bin_load) begin
         s2_ff <= nb_ff * n2_ff;
         for (int k = 0; k < 3; k++) begin
            if (quo_ff[k] >= DW'(n_eff[k])) begin
               bin_ff[k] <= BW'(n_eff[k] - AW'(1));
            end else begin
               bin_ff[k] <= quo_ff[k][BW-1:0];
            end
         end
      end
   end

   assign j1    = ohs_pkg::wrap_step(bin_ff[0], cmd.d1, n1_ff);
   assign jb    = ohs_pkg::wrap_step(bin_ff[1], cmd.db, nb_ff);
   assign moved = 2'((cmd.d1 != ohs_pkg::OFS_HOLD)) + 2'((cmd.db != ohs_pkg::OFS_HOLD))
                + 2'((cmd.d2 != ohs_pkg::OFS_HOLD));

   always_comb begin
      if (!smooth_ff) begin
         w_in = ohs_pkg::W_W'(ohs_pkg::W_ONE);
      end else begin
         case (moved)
            2'd0:    w_in = ohs_pkg::W_W'(ohs_pkg::W_CENTRE);
            2'd1:    w_in = ohs_pkg::W_W'(ohs_pkg::W_FACE);
            2'd2:    w_in = ohs_pkg::W_W'(ohs_pkg::W_EDGE);
            default: w_in = ohs_pkg::W_W'(ohs_pkg::W_CORNER);
         endcase
      end
   end

   assign addr_full_in = is_read_ff ? ohs_pkg::SUM_W'(rindex_ff)
                       : ohs_pkg::SUM_W'(p1_ff) + ohs_pkg::SUM_W'(pb_ff)
                         + ohs_pkg::SUM_W'(j2_ff);

   assign sum_in = {1'b0, ram_rdata} + (ohs_pkg::CELL_W + 1)'(w_ff);
   assign sat_in = sum_in[ohs_pkg::CELL_W] ? ohs_pkg::CELL_MAX
                                           : sum_in[ohs_pkg::CELL_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.addr_a) begin
         p1_ff     <= j1 * s2_ff;
         pb_ff     <= ohs_pkg::STRIDE_W'(jb) * ohs_pkg::STRIDE_W'(n2_ff);
         j2_ff     <= ohs_pkg::wrap_step(bin_ff[2], cmd.d2, n2_ff);
         w_ff      <= w_in;
         centre_ff <= (moved == 2'd0);
      end
      if (cmd.addr_b) begin
         addr_ff     <= addr_full_in[CA-1:0];
         in_range_ff <= (addr_full_in < ohs_pkg::SUM_W'(ohs_pkg::MAX_CELLS));
         if (centre_ff) centre_idx_ff <= addr_full_in[ohs_pkg::IDX_IN_W-1:0];
      end
      if (cmd.wr) begin
         val_ff <= in_range_ff ? ram_rdata : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_addr_ff <= clr_addr_ff + CA'(1);
      end
   end

   // Sweep zeros after reset; otherwise write back the saturated sum.
   assign ram_we    = cmd.clr_step || (cmd.wr && in_range_ff && !is_read_ff);
   assign ram_waddr = cmd.clr_step ? clr_addr_ff : addr_ff;
   assign ram_wdata = cmd.clr_step ? '0 : sat_in;

   ohs_ram #(
      .WIDTH (ohs_pkg::CELL_W),
      .DEPTH (ohs_pkg::MAX_CELLS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (addr_ff),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_index_ff <= is_read_ff ? rindex_ff : centre_idx_ff;
         rsp_value_ff <= is_read_ff ? val_ff : '0;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign cell_index = rsp_index_ff;
   assign cell_value = rsp_value_ff;

   assign sts.is_read  = cmd.load ? req_type : is_read_ff;
   assign sts.smooth   = smooth_ff;
   assign sts.clr_last = (clr_addr_ff == CA'(ohs_pkg::MAX_CELLS - 1));
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;

endmodule

[sv/orientation_histogram_smoothed.sv]
// Top level of the smoothed 3D orientation histogram.
//
//  channel  | direction | signals                              | payload
//  req      | in        | req_tvalid/req_tready/req_tdata/user | angles, read index, kind
//  rsp      | out       | rsp_tvalid/rsp_tready/rsp_tdata      | cell index, cell value
//  csr      | in        | csr_we/csr_index/csr_wdata           | settings registers 0..4
//
// After reset the block sweeps zeros through all 262144 cells, one per cycle, and
// takes no beat on req during the sweep; csr writes are taken throughout. A read
// skips the angle division and binning; an accumulate runs bit-serial division of the
// angles and a binning step. Each cell then takes address multiply, address sum, read,
// read wait and write on the one histogram RAM port pair; the result is then loaded,
// and the next beat can be taken in the cycle after. One item is in flight at a time;
// a finished result waits in the rsp register, and the next beat is accepted
// meanwhile, stalling only when its own result is ready.
module orientation_histogram_smoothed (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // phi1_angle, big_phi_angle, phi2_angle, read_index
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // cell_index, cell_value
   input  logic                            csr_we,
   input  logic [ohs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ohs_pkg::CSR_W-1:0]       csr_wdata
);

   ohs_pkg::cmd_type cmd;
   ohs_pkg::sts_type sts;
   logic [ohs_pkg::IDX_IN_W-1:0] cell_index;
   logic [ohs_pkg::CELL_W-1:0]   cell_value;

   ohs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ohs_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_type      (req_tuser),
      .phi1_angle    (req_tdata[15:0]),
      .big_phi_angle (req_tdata[30:16]),
      .phi2_angle    (req_tdata[46:31]),
      .read_index    (req_tdata[64:47]),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .cell_index    (cell_index),
      .cell_value    (cell_value)
   );

   // Pack the result beat, zero-fill to whole bytes.
   assign rsp_tdata = {6'd0, cell_value, cell_index};

endmodule
